// ----- hw/rtl/servo_bus_packet_framer_macros.svh -----
// ----------------------------------------------------------------------------
// servo_bus_packet_framer_macros
// assertion macros for the framer rtl
// ----------------------------------------------------------------------------
`ifndef SERVO_BUS_PACKET_FRAMER_MACROS_SVH
`define SERVO_BUS_PACKET_FRAMER_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define SBPF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// condition must never be seen out of reset
`define SBPF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SBPF_ASSERT(lbl, prop, msg)
`define SBPF_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- hw/rtl/sbpf_pkg.sv -----
// ----------------------------------------------------------------------------
// sbpf_pkg
// types, framing constants and crc step for the servo bus packet framer
// ----------------------------------------------------------------------------
package sbpf_pkg;

  // input item kinds
  typedef enum logic {
    CMD_START = 1'b0,
    CMD_PARAM = 1'b1
  } cmd_e;

  // framing bytes
  localparam logic [7:0]  SYNC_BYTE    = 8'hFF;
  localparam logic [7:0]  V2_HDR_BYTE  = 8'hFD;
  localparam logic [7:0]  V2_RSV_BYTE  = 8'h00;
  localparam logic [7:0]  REFUSE_BYTE  = 8'h00;
  localparam logic [15:0] CRC_POLY     = 16'h8005;

  // count limits and length offsets
  localparam logic [15:0] V1_MAX_COUNT = 16'd253;
  localparam logic [15:0] V2_MAX_COUNT = 16'd65532;
  localparam logic [15:0] V2_LEN_ADD   = 16'd3;
  localparam logic [7:0]  V1_LEN_ADD   = 8'd2;

  // byte counts per packet part
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] V2_HDR_LEN = 4'd8;
  localparam logic [STEP_W-1:0] V1_HDR_LEN = 4'd5;
  localparam logic [STEP_W-1:0] V2_CHK_LEN = 4'd2;
  localparam logic [STEP_W-1:0] V1_CHK_LEN = 4'd1;
  localparam logic [STEP_W-1:0] ONE_STEP   = 4'd1;
  localparam logic [STEP_W-1:0] NO_STEP    = 4'd0;
  // v1 header bytes before this step are sync bytes, not summed
  localparam logic [STEP_W-1:0] V1_SUM_FIRST = 4'd2;

  // one input item
  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  device_id;
    logic [7:0]  instruction;
    logic [15:0] param_count;
    logic [7:0]  param_byte;
  } item_t;

  // one result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       refused;
  } result_t;

  // sequencer status seen by the top level
  typedef struct packed {
    logic        item_valid;
    logic        packet_open;
    logic [15:0] bytes_remaining;
  } status_t;

  // crc-16 0x8005, msb first, one byte
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/sbpf_seq.sv -----
// ----------------------------------------------------------------------------
// sbpf_seq
// item register and byte sequencer: while the output stage is ready, emits one packet byte per cycle
// ----------------------------------------------------------------------------
module sbpf_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              protocol_version_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sbpf_pkg::item_t   item_i,
  input  logic              res_ready_i,
  output logic              res_valid_o,
  output sbpf_pkg::result_t res_o,
  output sbpf_pkg::status_t status_o
);

  localparam int unsigned SW = sbpf_pkg::STEP_W;

  // item register
  logic            item_valid_q;
  sbpf_pkg::item_t item_q;
  logic [SW-1:0]   step_q, step_d;

  // packet state
  logic        open_q, open_d;
  logic        mode_q, mode_d;
  logic [15:0] remaining_q, remaining_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  sum_q, sum_d;

  // per-item decode
  logic          is_start, imode, refuse, drop, has_chk, in_hdr, fire, done;
  logic [SW-1:0] hdr_len, chk_len, total, chk_idx;
  logic [15:0]   len_v2, crc_base;
  logic [7:0]    len_v1, sum_base, cur_byte, hdr_byte, chk_byte;

  // decode the held item against the packet state
  always_comb begin
    is_start = (item_q.cmd == sbpf_pkg::CMD_START);
    imode    = is_start ? protocol_version_i : mode_q;
    refuse   = is_start && (protocol_version_i ? (item_q.param_count > sbpf_pkg::V2_MAX_COUNT)
                                               : (item_q.param_count > sbpf_pkg::V1_MAX_COUNT));
    drop     = !is_start && !open_q;
    if (refuse || !is_start) begin
      hdr_len = sbpf_pkg::ONE_STEP;
    end else begin
      hdr_len = protocol_version_i ? sbpf_pkg::V2_HDR_LEN : sbpf_pkg::V1_HDR_LEN;
    end
    has_chk  = !refuse && (is_start ? (item_q.param_count == 16'd0) : (remaining_q == 16'd1));
    if (has_chk) begin
      chk_len = imode ? sbpf_pkg::V2_CHK_LEN : sbpf_pkg::V1_CHK_LEN;
    end else begin
      chk_len = sbpf_pkg::NO_STEP;
    end
    total    = drop ? sbpf_pkg::NO_STEP : hdr_len + chk_len;
    in_hdr   = (step_q < hdr_len);
    chk_idx  = step_q - hdr_len;
    len_v2   = item_q.param_count + sbpf_pkg::V2_LEN_ADD;
    len_v1   = item_q.param_count[7:0] + sbpf_pkg::V1_LEN_ADD;
  end

  // header or parameter byte
  always_comb begin
    hdr_byte = item_q.param_byte;
    if (refuse) begin
      hdr_byte = sbpf_pkg::REFUSE_BYTE;
    end else if (is_start && protocol_version_i) begin
      case (step_q)
        4'd0, 4'd1: hdr_byte = sbpf_pkg::SYNC_BYTE;
        4'd2:       hdr_byte = sbpf_pkg::V2_HDR_BYTE;
        4'd3:       hdr_byte = sbpf_pkg::V2_RSV_BYTE;
        4'd4:       hdr_byte = item_q.device_id;
        4'd5:       hdr_byte = len_v2[7:0];
        4'd6:       hdr_byte = len_v2[15:8];
        default:    hdr_byte = item_q.instruction;
      endcase
    end else if (is_start) begin
      case (step_q)
        4'd0, 4'd1: hdr_byte = sbpf_pkg::SYNC_BYTE;
        4'd2:       hdr_byte = item_q.device_id;
        4'd3:       hdr_byte = len_v1;
        default:    hdr_byte = item_q.instruction;
      endcase
    end
  end

  // check bytes
  always_comb begin
    if (imode) begin
      chk_byte = chk_idx[0] ? crc_q[15:8] : crc_q[7:0];
    end else begin
      chk_byte = ~sum_q;
    end
    cur_byte = in_hdr ? hdr_byte : chk_byte;
  end

  // handshake toward the output stage and the input side
  always_comb begin
    fire        = item_valid_q && !drop && res_ready_i;
    done        = item_valid_q && (drop || (fire && (step_q == total - sbpf_pkg::ONE_STEP)));
    in_ready_o  = !item_valid_q || done;
    res_valid_o = fire;
    res_o.out_byte = cur_byte;
    res_o.out_last = refuse || (!in_hdr && (chk_idx == chk_len - sbpf_pkg::ONE_STEP));
    res_o.refused  = refuse;
  end

  // fold emitted header and parameter bytes into crc and sum, update packet state at item end
  always_comb begin
    crc_base    = (is_start && (step_q == sbpf_pkg::NO_STEP)) ? 16'd0 : crc_q;
    sum_base    = (is_start && (step_q == sbpf_pkg::NO_STEP)) ? 8'd0 : sum_q;
    crc_d       = crc_q;
    sum_d       = sum_q;
    open_d      = open_q;
    mode_d      = mode_q;
    remaining_d = remaining_q;
    step_d      = step_q;
    if (fire && !refuse && in_hdr) begin
      crc_d = imode ? sbpf_pkg::crc_feed(crc_base, cur_byte) : crc_base;
      if (!imode && (!is_start || (step_q >= sbpf_pkg::V1_SUM_FIRST))) begin
        sum_d = sum_base + cur_byte;
      end else begin
        sum_d = sum_base;
      end
    end
    if (done) begin
      step_d = sbpf_pkg::NO_STEP;
      if (is_start) begin
        open_d      = !refuse && (item_q.param_count != 16'd0);
        remaining_d = refuse ? 16'd0 : item_q.param_count;
        if (!refuse) begin
          mode_d = protocol_version_i;
        end
      end else if (open_q) begin
        remaining_d = remaining_q - 16'd1;
        open_d      = (remaining_q != 16'd1);
      end
    end else if (fire) begin
      step_d = step_q + sbpf_pkg::ONE_STEP;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      step_q       <= '0;
      open_q       <= 1'b0;
      mode_q       <= 1'b0;
      remaining_q  <= '0;
      crc_q        <= '0;
      sum_q        <= '0;
    end else begin
      if (in_ready_o) begin
        item_valid_q <= in_valid_i;
      end
      step_q      <= step_d;
      open_q      <= open_d;
      mode_q      <= mode_d;
      remaining_q <= remaining_d;
      crc_q       <= crc_d;
      sum_q       <= sum_d;
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

  assign status_o.item_valid      = item_valid_q;
  assign status_o.packet_open     = open_q;
  assign status_o.bytes_remaining = remaining_q;

endmodule

// ----- hw/rtl/sbpf_out.sv -----
// ----------------------------------------------------------------------------
// sbpf_out
// output register holding one result item toward the stream sink
// ----------------------------------------------------------------------------
module sbpf_out (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sbpf_pkg::result_t res_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sbpf_pkg::result_t res_o
);

  logic              valid_q;
  sbpf_pkg::result_t res_q;

  // slot is free when empty or being drained
  assign in_ready_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- hw/rtl/servo_bus_packet_framer.sv -----
// ----------------------------------------------------------------------------
// servo_bus_packet_framer
// frames servo bus instruction packets, one wire byte per output item
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries commands: tuser 0 starts a packet (id, instruction, count
//   in tdata), tuser 1 carries one parameter byte. m_axis carries the packet
//   bytes, tlast on the final check byte or on a refusal, tuser flags refusal.
//   cfg_we_i/cfg_wdata_i select framing: 1 crc-16 with length word, 0 checksum.
// Path: an accepted item is held in the item register; its bytes then pass the output register to m_axis.
// Throughput: one output byte per cycle while m_axis_tready is high, set by the single byte sequencer.
//   A start item gives 8 bytes (crc) or 5 (checksum), plus 2 or 1 check bytes
//   when the count is zero; a parameter item gives 1 byte, plus the check bytes
//   after the last one; a refusal gives 1 byte; a parameter outside a packet
//   is dropped with no output.
// Reset: no packet open, crc framing selected, both stages empty.
// Stall: when m_axis_tready is low the output register holds its byte, the
//   sequencer waits and s_axis_tready falls once the item register is busy.
// ----------------------------------------------------------------------------
`include "servo_bus_packet_framer_macros.svh"

module servo_bus_packet_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,    // protocol_version
  // command stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // device_id, instruction, param_count, param_byte
  input  logic        s_axis_tuser,   // cmd
  // byte stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // out_byte
  output logic        m_axis_tlast,
  output logic        m_axis_tuser    // refused
);

  logic              protocol_version_q;
  sbpf_pkg::item_t   item;
  sbpf_pkg::result_t seq_res, out_res;
  sbpf_pkg::status_t status;
  logic              seq_valid, out_ready;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      protocol_version_q <= 1'b1;
    end else if (cfg_we_i) begin
      protocol_version_q <= cfg_wdata_i;
    end
  end

  // unpack the command item
  assign item.cmd         = sbpf_pkg::cmd_e'(s_axis_tuser);
  assign item.device_id   = s_axis_tdata[7:0];
  assign item.instruction = s_axis_tdata[15:8];
  assign item.param_count = s_axis_tdata[31:16];
  assign item.param_byte  = s_axis_tdata[39:32];

  sbpf_seq u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .protocol_version_i (protocol_version_q),
    .in_valid_i         (s_axis_tvalid),
    .in_ready_o         (s_axis_tready),
    .item_i             (item),
    .res_ready_i        (out_ready),
    .res_valid_o        (seq_valid),
    .res_o              (seq_res),
    .status_o           (status)
  );

  sbpf_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (seq_valid),
    .in_ready_o  (out_ready),
    .res_i       (seq_res),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .res_o       (out_res)
  );

  assign m_axis_tdata = out_res.out_byte;
  assign m_axis_tlast = out_res.out_last;
  assign m_axis_tuser = out_res.refused;

  // checks
  `SBPF_ASSERT(a_refuse_shape, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'h00), "refusal must be a single zero byte with tlast")
  `SBPF_ASSERT(a_idle_ready, !status.item_valid |-> s_axis_tready, "input must be ready while no item is held")
  `SBPF_ASSERT_NEVER(a_closed_count, !status.packet_open && (status.bytes_remaining != 16'd0), "closed packet with parameter bytes pending")

endmodule

// ----- tb/tb_servo_bus_packet_framer.sv -----
// ----------------------------------------------------------------------------
// tb_servo_bus_packet_framer
// self-checking bench for the servo bus packet framer: a directed sequence
// covers the count limits, zero counts, abandoned packets, stray parameter
// bytes and a framing change inside an open packet; then random phases send
// mostly well-formed packets with random content under both framings, with
// random idling on both streams. a scoreboard predicts every wire byte.
// ----------------------------------------------------------------------------
module tb_servo_bus_packet_framer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 370;      // directed part plus random items, all counted
  localparam int PHASE_ITEMS = 40;
  localparam int SETTLE      = 16;       // cycles let pass once nothing is expected
  localparam int DRAIN_LIMIT = 5000;

  // framing bytes, kept apart from the rtl's own constants
  localparam logic [7:0]  SYNC       = 8'hFF;
  localparam logic [7:0]  HDR_MARK   = 8'hFD;
  localparam logic [7:0]  HDR_RSV    = 8'h00;
  localparam logic [15:0] POLY       = 16'h8005;
  localparam logic [15:0] CRC_LIMIT  = 16'd65532;
  localparam logic [15:0] SUM_LIMIT  = 16'd253;
  localparam bit          FRAME_SUM  = 1'b0;
  localparam bit          FRAME_CRC  = 1'b1;

  // ---------------------------------------------------------------------------
  // wire byte predictor and store of expected bytes
  // ---------------------------------------------------------------------------
  class frame_scoreboard;
    bit                version_reg = FRAME_CRC;
    bit                open;
    bit                crc_mode;
    logic [15:0]       remaining;
    logic [15:0]       crc;
    logic [7:0]        sum;
    sbpf_pkg::result_t pending_bytes[$];
    int                packets;
    int                refusals;
    int                dropped;
    int                checked;

    function void set_version(bit v);
      version_reg = v;
    endfunction

    function int pending();
      return pending_bytes.size();
    endfunction

    function void flush();
      pending_bytes.delete();
    endfunction

    // crc-16 0x8005, msb first, no reflection
    function logic [15:0] crc_step(logic [15:0] c_in, logic [7:0] val);
      logic [15:0] c;
      c = c_in ^ {val, 8'h00};
      for (int k = 0; k < 8; k++) begin
        c = c[15] ? ({c[14:0], 1'b0} ^ POLY) : {c[14:0], 1'b0};
      end
      return c;
    endfunction

    function void put_result(logic [7:0] val, logic last, logic refused);
      sbpf_pkg::result_t r;
      r.out_byte = val;
      r.out_last = last;
      r.refused  = refused;
      pending_bytes.push_back(r);
    endfunction

    // packet byte, folded into the crc when crc framing is latched
    function void emit_byte(logic [7:0] val);
      if (crc_mode) crc = crc_step(crc, val);
      put_result(val, 1'b0, 1'b0);
    endfunction

    function void close_packet();
      if (crc_mode) begin
        put_result(crc[7:0], 1'b0, 1'b0);
        put_result(crc[15:8], 1'b1, 1'b0);
      end else begin
        put_result(~sum, 1'b1, 1'b0);
      end
      open = 1'b0;
      remaining = '0;
      packets++;
    endfunction

    // returns the number of wire bytes the item causes
    function int note_item(sbpf_pkg::item_t it);
      int          before_n;
      logic [15:0] len16;
      logic [7:0]  len8;
      before_n = pending_bytes.size();
      if (it.cmd == sbpf_pkg::CMD_START) begin
        open = 1'b0;
        remaining = '0;
        if (it.param_count > (version_reg ? CRC_LIMIT : SUM_LIMIT)) begin
          put_result(8'h00, 1'b1, 1'b1);
          refusals++;
          return 1;
        end
        crc_mode = version_reg;
        crc = '0;
        sum = '0;
        if (crc_mode) begin
          len16 = it.param_count + 16'd3;
          emit_byte(SYNC);
          emit_byte(SYNC);
          emit_byte(HDR_MARK);
          emit_byte(HDR_RSV);
          emit_byte(it.device_id);
          emit_byte(len16[7:0]);
          emit_byte(len16[15:8]);
          emit_byte(it.instruction);
        end else begin
          len8 = it.param_count[7:0] + 8'd2;
          emit_byte(SYNC);
          emit_byte(SYNC);
          emit_byte(it.device_id);
          emit_byte(len8);
          emit_byte(it.instruction);
          sum = it.device_id + len8 + it.instruction;
        end
        open = 1'b1;
        remaining = it.param_count;
        if (it.param_count == '0) close_packet();
      end else begin
        if (!open) begin
          dropped++;
          return 0;
        end
        emit_byte(it.param_byte);
        if (!crc_mode) sum = sum + it.param_byte;
        remaining = remaining - 16'd1;
        if (remaining == '0) close_packet();
      end
      return pending_bytes.size() - before_n;
    endfunction

    // empty string when the byte matches the oldest expectation
    function string check_result(sbpf_pkg::result_t got);
      sbpf_pkg::result_t want;
      string             why;
      if (pending_bytes.size() == 0) begin
        return $sformatf("unexpected byte %02h last %0b refused %0b",
                         got.out_byte, got.out_last, got.refused);
      end
      want = pending_bytes.pop_front();
      checked++;
      why = "";
      if (got.out_byte !== want.out_byte)
        why = {why, $sformatf(" byte got %02h want %02h", got.out_byte, want.out_byte)};
      if (got.out_last !== want.out_last)
        why = {why, $sformatf(" last got %0b want %0b", got.out_last, want.out_last)};
      if (got.refused !== want.refused)
        why = {why, $sformatf(" refused got %0b want %0b", got.refused, want.refused)};
      if (why != "") why = $sformatf("byte #%0d:%s", checked, why);
      return why;
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // signals and block
  // ---------------------------------------------------------------------------
  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata;   // device_id, instruction, param_count, param_byte
  logic        s_axis_tuser;   // cmd
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // out_byte
  logic        m_axis_tlast;
  logic        m_axis_tuser;   // refused

  frame_scoreboard sb;
  int mismatches;
  int items_sent;
  int version_writes;
  int idle_max;
  bit cur_version;

  servo_bus_packet_framer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  function automatic int draw_gap();
    return (idle_max == 0) ? 0 : $urandom_range(0, idle_max);
  endfunction

  // ---------------------------------------------------------------------------
  // byte stream: receiver stalls and checking
  // ---------------------------------------------------------------------------
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    sbpf_pkg::result_t got;
    string             why;
    if (rst_ni === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      got.out_byte = m_axis_tdata;
      got.out_last = m_axis_tlast;
      got.refused  = m_axis_tuser;
      why = sb.check_result(got);
      if (why != "") report_mismatch(why);
    end
  end

  // ---------------------------------------------------------------------------
  // command stream driving
  // ---------------------------------------------------------------------------
  task automatic send_item(input sbpf_pkg::item_t it);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tdata  <= {it.param_byte, it.param_count, it.instruction, it.device_id};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    void'(sb.note_item(it));
    items_sent++;
  endtask

  task automatic send_start(input logic [7:0] id, input logic [7:0] inst,
                            input logic [15:0] cnt);
    sbpf_pkg::item_t it;
    it.cmd         = sbpf_pkg::CMD_START;
    it.device_id   = id;
    it.instruction = inst;
    it.param_count = cnt;
    it.param_byte  = 8'($urandom);
    send_item(it);
  endtask

  task automatic send_param(input logic [7:0] pb);
    sbpf_pkg::item_t it;
    it.cmd         = sbpf_pkg::CMD_PARAM;
    it.device_id   = 8'($urandom);
    it.instruction = 8'($urandom);
    it.param_count = 16'($urandom);
    it.param_byte  = pb;
    send_item(it);
  endtask

  // drop valid, wait for every expected byte, then let the pipeline drain
  task automatic wait_idle();
    int n;
    s_axis_tvalid <= 1'b0;
    n = 0;
    while (sb.pending() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    if (sb.pending() != 0) begin
      report_mismatch($sformatf("%0d expected bytes never arrived", sb.pending()));
      sb.flush();
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_version(input bit v);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.set_version(v);
    cur_version = v;
    version_writes++;
  endtask

  // one random packet shape: mostly well formed, some broken or noise
  task automatic random_packet();
    int pick;
    int cnt;
    int n_par;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
      send_start(8'($urandom), 8'($urandom), 16'(cnt));
      repeat (cnt) send_param(8'($urandom));
    end else if (pick < 80) begin
      // truncated packet, abandoned by the next start
      cnt = $urandom_range(2, cur_version ? 300 : 253);
      n_par = $urandom_range(0, (cnt - 1 < 5) ? cnt - 1 : 5);
      send_start(8'($urandom), 8'($urandom), 16'(cnt));
      repeat (n_par) send_param(8'($urandom));
    end else if (pick < 88) begin
      cnt = cur_version ? $urandom_range(65533, 65535) : $urandom_range(254, 65535);
      send_start(8'($urandom), 8'($urandom), 16'(cnt));
    end else if (pick < 95) begin
      send_param(8'($urandom));
    end else begin
      send_start(8'($urandom), 8'($urandom), 16'($urandom));
      repeat ($urandom_range(0, 3)) send_param(8'($urandom));
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int phase;
    sb = new();
    mismatches     = 0;
    items_sent     = 0;
    version_writes = 0;
    idle_max       = 0;
    cur_version    = FRAME_CRC;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    m_axis_tready <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed: crc framing out of reset
    idle_max = 2;
    send_param(8'h5A);                    // nothing open, dropped
    send_start(8'hFF, 8'hFF, 16'd0);      // zero count, crc right after header
    send_start(8'h00, 8'h00, 16'd65532);  // largest crc count, length word ffff
    send_param(8'h00);
    send_start(8'h5A, 8'h03, 16'd65533);  // refused, closes the open packet
    send_start(8'h11, 8'h22, 16'hFFFF);   // refused
    send_param(8'hC3);                    // dropped after a refusal
    send_start(8'h01, 8'h02, 16'd2);
    send_param(8'hFF);
    send_start(8'h07, 8'h08, 16'd1);      // abandons the open packet
    send_param(8'h00);
    send_start(8'hA5, 8'h5A, 16'd3);
    send_param(8'h12);
    // framing change inside an open packet keeps crc framing
    wait_idle();
    write_version(FRAME_SUM);
    send_param(8'h34);
    send_param(8'h56);
    // directed: checksum framing
    send_start(8'h3C, 8'h01, 16'd254);    // refused in checksum framing
    send_start(8'hFF, 8'hFF, 16'd253);    // length byte ff
    send_param(8'hFF);
    send_start(8'hFF, 8'hFF, 16'd0);      // abandons, checksum right after header
    send_start(8'h80, 8'h7F, 16'd1);
    send_param(8'hAA);
    send_param(8'h55);                    // dropped
    send_start(8'h42, 8'h24, 16'd2);
    send_param(8'h99);
    wait_idle();
    write_version(FRAME_CRC);
    send_param(8'h66);                    // closes with checksum framing

    // random phases under both framings and several idling levels
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      wait_idle();
      write_version((phase < 2) ? phase[0] : 1'($urandom_range(0, 1)));
      case (phase % 3)
        0: idle_max = 0;
        1: idle_max = 10;
        default: idle_max = 3;
      endcase
      for (int k = 0; k < PHASE_ITEMS && items_sent < ITEM_TARGET; k++) random_packet();
      phase++;
    end
    wait_idle();

    $display("covered %0d items in %0d random phases, %0d framing writes",
             items_sent, phase, version_writes);
    $display("checked %0d bytes: %0d packets closed, %0d refusals, %0d bytes dropped",
             sb.checked, sb.packets, sb.refusals, sb.dropped);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ----- servo_bus_packet_framer.f -----
+incdir+hw/rtl
hw/rtl/sbpf_pkg.sv
hw/rtl/sbpf_seq.sv
hw/rtl/sbpf_out.sv
hw/rtl/servo_bus_packet_framer.sv
tb/tb_servo_bus_packet_framer.sv
